// ===== design/pit_pkg.sv =====
// Shared types and constants for the three-channel interval timer.
// No dependencies; the top level and pit_core refer to it by scoped names.
package pit_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int CH_W = 2;

	localparam logic [16:0] FULL_COUNT = 17'h10000;
	localparam int PIT_FREQ = 1193182;
	localparam logic [16:0] FALLBACK_COUNT = 17'((PIT_FREQ + 50) / 100);
	localparam logic [7:0] MISC_OUT2 = 8'h20;
	localparam logic [7:0] BYTE_MASK = 8'hff;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [2:0] PORT_CTRL = 3'd3;
	localparam logic [2:0] PORT_MISC = 3'd4;

	localparam logic [2:0] MODE_0 = 3'd0;
	localparam logic [2:0] MODE_1 = 3'd1;
	localparam logic [2:0] MODE_2 = 3'd2;
	localparam logic [2:0] MODE_3 = 3'd3;
	localparam logic [2:0] MODE_4 = 3'd4;
	localparam logic [2:0] MODE_5 = 3'd5;
	localparam logic [2:0] MODE_6 = 3'd6;

	localparam logic [1:0] RW_LATCH = 2'd0;
	localparam logic [1:0] RW_BOTH  = 2'd3;
	localparam logic [1:0] SEL_READBACK = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] port_sel;
		logic [2:0] access_bytes;
		logic [7:0] wdata;
	} item_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       access_error;
		logic       irq_pulse;
	} result_t;

endpackage

// ===== design/programmable_interval_timer.sv =====
// Top level of the three-channel interval timer: input and result registers.
// Depends on pit_pkg and pit_core.
//
// Takes one word per clock while req_stall is low: a tick, a port write or a port
// read, and returns exactly one result word for each. A word is taken into the
// input register, worked through the combinational channel logic in pit_core
// and written to the result register when that register is free or being read,
// so a new word can follow every cycle unless rsp_stall holds a full result;
// req_stall rises only while the result register is full and rsp_stall holds
// it. Counts are 16-bit binary, LSB then MSB, modes 0, 2, 3 and 4; a tick
// advances every loaded channel by one count.
module programmable_interval_timer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] cmd,
	input  logic [2:0] port_sel,
	input  logic [2:0] access_bytes,
	input  logic [7:0] wdata,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [7:0] rdata,
	output logic       access_error,
	output logic       irq_pulse
);

	pit_pkg::item_t   item_s1;
	logic             valid_s1;
	pit_pkg::result_t result_q;
	logic             rsp_valid_q;
	pit_pkg::result_t core_result;
	logic             advance;

	assign advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= '{cmd: cmd, port_sel: port_sel, access_bytes: access_bytes, wdata: wdata};
		end
	end

	pit_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rdata = result_q.rdata;
	assign access_error = result_q.access_error;
	assign irq_pulse = result_q.irq_pulse;

endmodule

// ===== design/pit_core.sv =====
// Channel state and the single-pass update logic for one timer word.
// Depends on pit_pkg for the word and result types and all codes.
module pit_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  pit_pkg::item_t   item,
	output pit_pkg::result_t result
);

	logic [2:0]  mode_q   [pit_pkg::NUM_CHANNELS];
	logic [16:0] reload_q [pit_pkg::NUM_CHANNELS];
	logic [7:0]  lo_q     [pit_pkg::NUM_CHANNELS];
	logic [7:0]  hi_q     [pit_pkg::NUM_CHANNELS];
	logic [1:0]  cbi_q    [pit_pkg::NUM_CHANNELS];
	logic [15:0] olatch_q [pit_pkg::NUM_CHANNELS];
	logic [1:0]  lleft_q  [pit_pkg::NUM_CHANNELS];
	logic        toggle_q [pit_pkg::NUM_CHANNELS];
	logic        null_q   [pit_pkg::NUM_CHANNELS];
	logic        stl_q    [pit_pkg::NUM_CHANNELS];
	logic [7:0]  stb_q    [pit_pkg::NUM_CHANNELS];
	logic [16:0] phase_q  [pit_pkg::NUM_CHANNELS];
	logic [15:0] rem_q    [pit_pkg::NUM_CHANNELS];
	logic        exp_q    [pit_pkg::NUM_CHANNELS];
	logic        run0_q;
	logic        pend0_q;

	logic [2:0]  n_mode   [pit_pkg::NUM_CHANNELS];
	logic [16:0] n_reload [pit_pkg::NUM_CHANNELS];
	logic [7:0]  n_lo     [pit_pkg::NUM_CHANNELS];
	logic [7:0]  n_hi     [pit_pkg::NUM_CHANNELS];
	logic [1:0]  n_cbi    [pit_pkg::NUM_CHANNELS];
	logic [15:0] n_olatch [pit_pkg::NUM_CHANNELS];
	logic [1:0]  n_lleft  [pit_pkg::NUM_CHANNELS];
	logic        n_toggle [pit_pkg::NUM_CHANNELS];
	logic        n_null   [pit_pkg::NUM_CHANNELS];
	logic        n_stl    [pit_pkg::NUM_CHANNELS];
	logic [7:0]  n_stb    [pit_pkg::NUM_CHANNELS];
	logic [16:0] n_phase  [pit_pkg::NUM_CHANNELS];
	logic [15:0] n_rem    [pit_pkg::NUM_CHANNELS];
	logic        n_exp    [pit_pkg::NUM_CHANNELS];
	logic        n_run0;
	logic        n_pend0;

	logic        cc_do  [pit_pkg::NUM_CHANNELS];
	logic        cc_lat [pit_pkg::NUM_CHANNELS];
	logic        rb_hit [pit_pkg::NUM_CHANNELS];
	logic [15:0] cv     [pit_pkg::NUM_CHANNELS];

	logic [pit_pkg::CH_W-1:0] ch_sel;
	logic [1:0]  sel;
	logic [1:0]  rw;
	logic [2:0]  m;
	logic        is_acc;
	logic        size_ok;
	logic        cw;
	logic        rd_cnt;
	logic        fire;
	logic [17:0] p;
	logic [16:0] np;
	logic [16:0] rp;
	logic [1:0]  widx;
	logic [1:0]  cbi_inc;
	logic [7:0]  new_lo;
	logic [7:0]  new_hi;
	logic        nc;
	logic        err;
	logic        irq;
	logic [7:0]  rdata;

	function automatic logic periodic(input logic [2:0] md);
		return (md == pit_pkg::MODE_2) || (md == pit_pkg::MODE_3);
	endfunction

	function automatic logic [16:0] cr_of(input logic [7:0] h, input logic [7:0] l);
		return ({h, l} == 16'd0) ? pit_pkg::FULL_COUNT : {1'b0, h, l};
	endfunction

	function automatic logic [15:0] count_value(input logic [2:0] md, input logic [16:0] init,
			input logic [16:0] ph, input logic [15:0] rm);
		logic [16:0] half;
		logic [16:0] t;
		logic [16:0] v;
		half = (init + 17'd1) >> 1;
		t = {1'b0, rm};
		if (t >= half)
			t = t - half;
		unique case (md)
			pit_pkg::MODE_2: v = init - {1'b0, rm};
			pit_pkg::MODE_3: v = {init[16:1], 1'b0} - {t[15:0], 1'b0};
			default:         v = init - ph;
		endcase
		return v[15:0];
	endfunction

	function automatic logic out_level(input logic [2:0] md, input logic ncf,
			input logic [16:0] init, input logic [16:0] ph, input logic [15:0] rm,
			input logic ex);
		logic [16:0] half;
		logic lvl;
		half = (init + 17'd1) >> 1;
		if (md == pit_pkg::MODE_0)
			lvl = ncf ? 1'b0 : ((init == 17'd0) || ex || (ph >= init));
		else if (ncf || (init == 17'd0))
			lvl = 1'b1;
		else if (md == pit_pkg::MODE_2)
			lvl = ({1'b0, rm} != (init - 17'd1));
		else if (md == pit_pkg::MODE_3)
			lvl = ({1'b0, rm} < half);
		else
			lvl = !((ph == init) && !ex);
		return lvl;
	endfunction

	always_comb begin
		n_mode = mode_q;
		n_reload = reload_q;
		n_lo = lo_q;
		n_hi = hi_q;
		n_cbi = cbi_q;
		n_olatch = olatch_q;
		n_lleft = lleft_q;
		n_toggle = toggle_q;
		n_null = null_q;
		n_stl = stl_q;
		n_stb = stb_q;
		n_phase = phase_q;
		n_rem = rem_q;
		n_exp = exp_q;
		n_run0 = run0_q;
		n_pend0 = pend0_q;
		err = 1'b0;
		irq = 1'b0;
		rdata = '0;
		fire = 1'b0;
		p = '0;
		np = '0;
		rp = '0;
		widx = '0;
		cbi_inc = '0;
		new_lo = '0;
		new_hi = '0;
		nc = 1'b0;

		ch_sel = item.port_sel[pit_pkg::CH_W-1:0];
		sel = item.wdata[7:6];
		rw = item.wdata[5:4];
		m = item.wdata[3:1];
		is_acc = (item.cmd == pit_pkg::CMD_WRITE) || (item.cmd == pit_pkg::CMD_READ);
		size_ok = (item.access_bytes == 3'd1);
		cw = (item.cmd == pit_pkg::CMD_WRITE) && (item.port_sel == pit_pkg::PORT_CTRL) && size_ok;
		rd_cnt = (item.cmd == pit_pkg::CMD_READ) && size_ok &&
			(item.port_sel < 3'(pit_pkg::NUM_CHANNELS));

		// count snapshot: fallback load, then optional latch
		for (int ch = 0; ch < pit_pkg::NUM_CHANNELS; ch++) begin
			rb_hit[ch] = cw && (sel == pit_pkg::SEL_READBACK) && item.wdata[ch + 1];
			cc_lat[ch] = rb_hit[ch] ? !item.wdata[5] :
				(cw && (sel == 2'(ch)) && (rw == pit_pkg::RW_LATCH));
			cc_do[ch] = rb_hit[ch] || cc_lat[ch] ||
				(rd_cnt && (ch_sel == 2'(ch)) && !stl_q[ch] && (lleft_q[ch] == 2'd0));
			cv[ch] = '0;
			if (cc_do[ch]) begin
				if (n_reload[ch] == 17'd0) begin
					n_reload[ch] = pit_pkg::FALLBACK_COUNT;
					n_phase[ch] = '0;
					n_rem[ch] = '0;
					n_exp[ch] = 1'b0;
				end
				cv[ch] = count_value(n_mode[ch], n_reload[ch], n_phase[ch], n_rem[ch]);
				if (cc_lat[ch] && (n_lleft[ch] == 2'd0)) begin
					n_lleft[ch] = 2'd2;
					n_olatch[ch] = cv[ch];
				end
			end
		end

		if (item.cmd == pit_pkg::CMD_TICK) begin
			for (int ch = 0; ch < pit_pkg::NUM_CHANNELS; ch++) begin
				fire = 1'b0;
				if (n_reload[ch] != 17'd0) begin
					if (periodic(n_mode[ch])) begin
						p = {1'b0, n_phase[ch]} + 18'd1;
						if (p >= {1'b0, n_reload[ch]}) begin
							n_phase[ch] = '0;
							n_rem[ch] = '0;
							fire = 1'b1;
						end else begin
							n_phase[ch] = p[16:0];
							n_rem[ch] = p[15:0];
						end
					end else begin
						if ((n_phase[ch] == n_reload[ch]) && !n_exp[ch]) begin
							n_exp[ch] = 1'b1;
							if (n_mode[ch] == pit_pkg::MODE_4)
								fire = 1'b1;
						end
						np = n_phase[ch] + 17'd1;
						rp = {1'b0, n_rem[ch]} + 17'd1;
						n_phase[ch] = np;
						if ((np == 17'd0) || (rp == n_reload[ch]))
							n_rem[ch] = '0;
						else
							n_rem[ch] = rp[15:0];
						if ((n_mode[ch] == pit_pkg::MODE_0) && !n_exp[ch] && (np == n_reload[ch]))
							fire = 1'b1;
					end
				end
				if ((ch == 0) && fire && n_run0) begin
					irq = 1'b1;
					if (n_pend0) begin
						n_pend0 = 1'b0;
						if (n_null[0] && (n_cbi[0] == 2'd2)) begin
							n_reload[0] = cr_of(n_hi[0], n_lo[0]);
							n_null[0] = 1'b0;
							n_cbi[0] = '0;
							n_phase[0] = '0;
							n_rem[0] = '0;
							n_exp[0] = 1'b0;
						end
					end
				end
			end
		end else if (is_acc) begin
			if (item.port_sel == pit_pkg::PORT_MISC) begin
				if ((item.cmd == pit_pkg::CMD_READ) && (pit_pkg::NUM_CHANNELS >= 3))
					rdata = out_level(n_mode[2], n_null[2], n_reload[2], n_phase[2],
						n_rem[2], n_exp[2]) ? pit_pkg::MISC_OUT2 : 8'd0;
			end else if (!size_ok) begin
				err = 1'b1;
			end else if (item.port_sel == pit_pkg::PORT_CTRL) begin
				if (item.cmd == pit_pkg::CMD_READ) begin
					err = 1'b1;
				end else if (sel == pit_pkg::SEL_READBACK) begin
					for (int ch = 0; ch < pit_pkg::NUM_CHANNELS; ch++) begin
						if (rb_hit[ch] && !item.wdata[4] && !n_stl[ch]) begin
							nc = ((ch == 0) && periodic(n_mode[ch])) ?
								(n_null[ch] && !n_run0) : n_null[ch];
							n_stb[ch] = {out_level(n_mode[ch], nc, n_reload[ch], n_phase[ch],
								n_rem[ch], n_exp[ch]), n_null[ch], 2'b11, n_mode[ch], 1'b0};
							n_stl[ch] = 1'b1;
						end
					end
				end else if (sel >= 2'(pit_pkg::NUM_CHANNELS)) begin
					err = 1'b1;
				end else if (rw == pit_pkg::RW_LATCH) begin
					err = 1'b0;
				end else if ((rw != pit_pkg::RW_BOTH) || (m == pit_pkg::MODE_1) ||
						(m == pit_pkg::MODE_5)) begin
					err = 1'b1;
				end else begin
					n_mode[sel] = (m >= pit_pkg::MODE_6) ? (m - 3'd4) : m;
					n_null[sel] = 1'b1;
					n_cbi[sel] = '0;
					n_lleft[sel] = '0;
					if (sel == 2'd0) begin
						n_run0 = 1'b0;
						n_pend0 = 1'b0;
					end
				end
			end else if (item.port_sel < 3'(pit_pkg::NUM_CHANNELS)) begin
				if (item.cmd == pit_pkg::CMD_READ) begin
					if (stl_q[ch_sel]) begin
						n_stl[ch_sel] = 1'b0;
						rdata = stb_q[ch_sel];
					end else if (lleft_q[ch_sel] == 2'd0) begin
						rdata = toggle_q[ch_sel] ? cv[ch_sel][15:8] : cv[ch_sel][7:0];
						n_toggle[ch_sel] = !toggle_q[ch_sel];
					end else begin
						n_lleft[ch_sel] = lleft_q[ch_sel] - 2'd1;
						rdata = (n_lleft[ch_sel] != 2'd0) ? olatch_q[ch_sel][7:0] :
							olatch_q[ch_sel][15:8];
					end
				end else begin
					widx = (cbi_q[ch_sel] >= 2'd2) ? 2'd0 : cbi_q[ch_sel];
					new_lo = (widx == 2'd0) ? item.wdata : lo_q[ch_sel];
					new_hi = (widx == 2'd0) ? hi_q[ch_sel] : item.wdata;
					n_lo[ch_sel] = new_lo;
					n_hi[ch_sel] = new_hi;
					cbi_inc = widx + 2'd1;
					n_cbi[ch_sel] = cbi_inc;
					if (cbi_inc == 2'd2) begin
						if (periodic(mode_q[ch_sel]) && (cr_of(new_hi, new_lo) == 17'd1)) begin
							n_lo[ch_sel] = '0;
							n_cbi[ch_sel] = '0;
							err = 1'b1;
						end else begin
							n_toggle[ch_sel] = 1'b0;
							n_null[ch_sel] = 1'b1;
							if ((ch_sel == 2'd0) && run0_q && periodic(mode_q[0])) begin
								n_pend0 = 1'b1;
							end else begin
								if (ch_sel == 2'd0) begin
									n_pend0 = 1'b0;
									n_run0 = 1'b1;
								end
								n_reload[ch_sel] = cr_of(new_hi, new_lo);
								n_null[ch_sel] = 1'b0;
								n_cbi[ch_sel] = '0;
								n_phase[ch_sel] = '0;
								n_rem[ch_sel] = '0;
								n_exp[ch_sel] = 1'b0;
							end
						end
					end
				end
			end else begin
				err = 1'b1;
			end
		end

		result.rdata = err ? 8'd0 : (rdata & pit_pkg::BYTE_MASK);
		result.access_error = err;
		result.irq_pulse = irq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < pit_pkg::NUM_CHANNELS; ch++) begin
				mode_q[ch] <= '0;
				reload_q[ch] <= '0;
				lo_q[ch] <= '0;
				hi_q[ch] <= '0;
				cbi_q[ch] <= '0;
				olatch_q[ch] <= '0;
				lleft_q[ch] <= '0;
				toggle_q[ch] <= 1'b0;
				null_q[ch] <= 1'b0;
				stl_q[ch] <= 1'b0;
				stb_q[ch] <= '0;
				phase_q[ch] <= '0;
				rem_q[ch] <= '0;
				exp_q[ch] <= 1'b0;
			end
			run0_q <= 1'b0;
			pend0_q <= 1'b0;
		end else if (en) begin
			mode_q <= n_mode;
			reload_q <= n_reload;
			lo_q <= n_lo;
			hi_q <= n_hi;
			cbi_q <= n_cbi;
			olatch_q <= n_olatch;
			lleft_q <= n_lleft;
			toggle_q <= n_toggle;
			null_q <= n_null;
			stl_q <= n_stl;
			stb_q <= n_stb;
			phase_q <= n_phase;
			rem_q <= n_rem;
			exp_q <= n_exp;
			run0_q <= n_run0;
			pend0_q <= n_pend0;
		end
	end

endmodule

// ===== design/pit_checker.sv =====
// Port-level checks for the interval timer, bound to the top level.
// Depends only on the top level's ports.
module pit_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [7:0] rdata,
	input logic       access_error,
	input logic       irq_pulse
);

	// refused access returns no data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && access_error |-> rdata == 8'd0)
		else $error("refused word carries data");

	// an interrupt comes only from a clean tick
	a_irq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && irq_pulse |-> !access_error && rdata == 8'd0)
		else $error("irq on a non-tick word");

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without output backpressure");

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rdata) && $stable(access_error)
			&& $stable(irq_pulse))
		else $error("stalled result changed");

endmodule

bind programmable_interval_timer pit_checker u_pit_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.rdata        (rdata),
	.access_error (access_error),
	.irq_pulse    (irq_pulse)
);

// ===== sim/tb_programmable_interval_timer.sv =====
`timescale 1ns / 100ps
// Testbench for programmable_interval_timer: directed and random tick, port write and
// port read words, checked field by field against a timer predictor kept in the bench.
// Depends on pit_pkg and the timer RTL.
module tb_programmable_interval_timer;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int ITEMS = 1200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] cmd = pit_pkg::CMD_TICK;
	logic [2:0] port_sel = 3'd0;
	logic [2:0] access_bytes = 3'd1;
	logic [7:0] wdata = 8'd0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [7:0] rdata;
	logic access_error;
	logic irq_pulse;

	programmable_interval_timer u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.cmd(cmd), .port_sel(port_sel), .access_bytes(access_bytes), .wdata(wdata),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.rdata(rdata), .access_error(access_error), .irq_pulse(irq_pulse)
	);

	always #2 clk = ~clk;

	// timer state
	logic [2:0] t_mode [3] = '{default: '0};
	int unsigned t_reload [3] = '{default: 0};
	int unsigned t_phase [3] = '{default: 0};
	logic [7:0] t_crb [6] = '{default: '0};
	int unsigned t_bidx [3] = '{default: 0};
	int unsigned t_lleft [3] = '{default: 0};
	logic [15:0] t_olatch [3] = '{default: '0};
	logic [7:0] t_stbyte [3] = '{default: '0};
	bit t_toggle [3] = '{default: 1'b0};
	bit t_nullc [3] = '{default: 1'b0};
	bit t_stlat [3] = '{default: 1'b0};
	bit t_expired [3] = '{default: 1'b0};
	bit ch0_run = 1'b0;
	bit ch0_pend = 1'b0;

	pit_pkg::item_t pending_words [$];
	pit_pkg::result_t expected_results [$];
	pit_pkg::item_t cur_word;
	int words_taken = 0;
	int mismatches = 0;
	bit word_taken = 1'b0;
	bit result_taken = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	bit quiet = 1'b0;

	function automatic bit is_periodic(logic [2:0] m);
		return m == pit_pkg::MODE_2 || m == pit_pkg::MODE_3;
	endfunction

	function automatic int unsigned count_reg(int ch);
		int unsigned v;
		v = 32'({t_crb[2*ch+1], t_crb[2*ch]});
		return v == 0 ? 32'(pit_pkg::FULL_COUNT) : v;
	endfunction

	function automatic void load_count(int ch);
		if (t_nullc[ch] && t_bidx[ch] == 2) begin
			t_reload[ch] = count_reg(ch);
			t_nullc[ch] = 1'b0;
			t_bidx[ch] = 0;
			t_phase[ch] = 0;
			t_expired[ch] = 1'b0;
		end
	endfunction

	function automatic logic [15:0] count_now(int ch, bit lat);
		int unsigned init, ph, t, half, v;
		if (t_reload[ch] == 0) begin
			t_reload[ch] = 32'(pit_pkg::FALLBACK_COUNT);
			t_phase[ch] = 0;
			t_expired[ch] = 1'b0;
		end
		init = t_reload[ch];
		ph = t_phase[ch];
		unique case (t_mode[ch])
			pit_pkg::MODE_2: v = init - ph % init;
			pit_pkg::MODE_3: begin
				t = ph % init;
				half = (init + 1) / 2;
				if (t >= half)
					t -= half;
				v = (init & ~32'd1) - 2 * t;
			end
			default: v = init - ph;
		endcase
		if (lat && t_lleft[ch] == 0) begin
			t_lleft[ch] = 2;
			t_olatch[ch] = v[15:0];
		end
		return v[15:0];
	endfunction

	function automatic bit out_high(int ch);
		bit nc;
		int unsigned init, ph;
		nc = t_nullc[ch];
		init = t_reload[ch];
		ph = t_phase[ch];
		if (ch == 0 && is_periodic(t_mode[ch]))
			nc = nc && !ch0_run;
		if (t_mode[ch] == pit_pkg::MODE_0)
			return nc ? 1'b0 : (init == 0 || t_expired[ch] || ph >= init);
		if (nc || init == 0)
			return 1'b1;
		if (t_mode[ch] == pit_pkg::MODE_2)
			return ph % init != init - 1;
		if (t_mode[ch] == pit_pkg::MODE_3)
			return ph % init < (init + 1) / 2;
		return !(ph == init && !t_expired[ch]);
	endfunction

	function automatic bit advance_tick();
		bit irq, fire;
		int unsigned init, p;
		irq = 1'b0;
		for (int ch = 0; ch < pit_pkg::NUM_CHANNELS; ch++) begin
			init = t_reload[ch];
			fire = 1'b0;
			if (init == 0)
				continue;
			if (is_periodic(t_mode[ch])) begin
				p = t_phase[ch] + 1;
				if (p >= init) begin
					p = 0;
					fire = 1'b1;
				end
				t_phase[ch] = p;
			end else begin
				if (t_phase[ch] == init && !t_expired[ch]) begin
					t_expired[ch] = 1'b1;
					if (t_mode[ch] == pit_pkg::MODE_4)
						fire = 1'b1;
				end
				t_phase[ch] = (t_phase[ch] + 1) & 32'h1ffff;
				if (t_mode[ch] == pit_pkg::MODE_0 && !t_expired[ch] && t_phase[ch] == init)
					fire = 1'b1;
			end
			if (ch == 0 && fire && ch0_run) begin
				irq = 1'b1;
				if (ch0_pend) begin
					ch0_pend = 1'b0;
					load_count(0);
				end
			end
		end
		return irq;
	endfunction

	function automatic void control_write(logic [7:0] val, ref bit err);
		logic [1:0] sel, rw;
		logic [2:0] m;
		logic [15:0] dummy;
		logic [7:0] s;
		sel = val[7:6];
		rw = val[5:4];
		m = val[3:1];
		if (sel == pit_pkg::SEL_READBACK) begin
			for (int ch = 0; ch < pit_pkg::NUM_CHANNELS; ch++) begin
				if (!val[ch+1])
					continue;
				dummy = count_now(ch, !val[5]);
				if (!val[4] && !t_stlat[ch]) begin
					s = 8'h30 | {4'd0, t_mode[ch], 1'b0};
					if (t_nullc[ch])
						s |= 8'h40;
					if (out_high(ch))
						s |= 8'h80;
					t_stbyte[ch] = s;
					t_stlat[ch] = 1'b1;
				end
			end
			return;
		end
		if (int'(sel) >= pit_pkg::NUM_CHANNELS) begin
			err = 1'b1;
			return;
		end
		if (rw == pit_pkg::RW_LATCH) begin
			dummy = count_now(int'(sel), 1'b1);
			return;
		end
		if (rw != pit_pkg::RW_BOTH || m == pit_pkg::MODE_1 || m == pit_pkg::MODE_5) begin
			err = 1'b1;
			return;
		end
		if (m >= pit_pkg::MODE_6)
			m -= 3'd4;
		t_mode[sel] = m;
		t_nullc[sel] = 1'b1;
		t_bidx[sel] = 0;
		t_lleft[sel] = 0;
		if (sel == 2'd0) begin
			ch0_run = 1'b0;
			ch0_pend = 1'b0;
		end
	endfunction

	function automatic void count_write(int ch, logic [7:0] val, ref bit err);
		if (t_bidx[ch] >= 2)
			t_bidx[ch] = 0;
		t_crb[2*ch + t_bidx[ch]] = val;
		t_bidx[ch]++;
		if (t_bidx[ch] != 2)
			return;
		if (is_periodic(t_mode[ch]) && count_reg(ch) == 1) begin
			t_crb[2*ch] = 8'd0;
			t_bidx[ch] = 0;
			err = 1'b1;
			return;
		end
		t_toggle[ch] = 1'b0;
		t_nullc[ch] = 1'b1;
		if (ch != 0) begin
			load_count(ch);
		end else if (ch0_run && is_periodic(t_mode[0])) begin
			ch0_pend = 1'b1;
		end else begin
			ch0_pend = 1'b0;
			load_count(0);
			ch0_run = 1'b1;
		end
	endfunction

	function automatic logic [7:0] count_read(int ch);
		logic [15:0] v;
		logic [7:0] r;
		if (t_stlat[ch]) begin
			t_stlat[ch] = 1'b0;
			return t_stbyte[ch];
		end
		if (t_lleft[ch] == 0) begin
			v = count_now(ch, 1'b0);
			r = t_toggle[ch] ? v[15:8] : v[7:0];
			t_toggle[ch] ^= 1'b1;
			return r;
		end
		t_lleft[ch]--;
		return t_lleft[ch] != 0 ? t_olatch[ch][7:0] : t_olatch[ch][15:8];
	endfunction

	function automatic pit_pkg::result_t timer_step(pit_pkg::item_t w);
		pit_pkg::result_t r;
		bit err, rd;
		r = '0;
		err = 1'b0;
		if (w.cmd == pit_pkg::CMD_TICK) begin
			r.irq_pulse = advance_tick();
		end else if (w.cmd != CMD_NONE) begin
			rd = w.cmd == pit_pkg::CMD_READ;
			if (w.port_sel == pit_pkg::PORT_MISC) begin
				if (rd)
					r.rdata = out_high(2) ? pit_pkg::MISC_OUT2 : 8'd0;
			end else if (w.access_bytes != 3'd1) begin
				err = 1'b1;
			end else if (w.port_sel == pit_pkg::PORT_CTRL) begin
				if (rd)
					err = 1'b1;
				else
					control_write(w.wdata, err);
			end else if (int'(w.port_sel) < pit_pkg::NUM_CHANNELS) begin
				if (rd)
					r.rdata = count_read(int'(w.port_sel));
				else
					count_write(int'(w.port_sel), w.wdata, err);
			end else begin
				err = 1'b1;
			end
		end
		if (err)
			r.rdata = '0;
		r.access_error = err;
		return r;
	endfunction

	task automatic push_word(logic [1:0] c, logic [2:0] p, logic [2:0] b, logic [7:0] d);
		pit_pkg::item_t w;
		w.cmd = c;
		w.port_sel = p;
		w.access_bytes = b;
		w.wdata = d;
		pending_words.push_back(w);
	endtask

	task automatic push_ctrl(logic [1:0] sel, logic [1:0] rw, logic [2:0] m);
		push_word(pit_pkg::CMD_WRITE, pit_pkg::PORT_CTRL, 3'd1, {sel, rw, m, 1'b0});
	endtask

	task automatic push_count(int ch, logic [15:0] v);
		push_word(pit_pkg::CMD_WRITE, 3'(ch), 3'd1, v[7:0]);
		push_word(pit_pkg::CMD_WRITE, 3'(ch), 3'd1, v[15:8]);
	endtask

	task automatic push_ticks(int n);
		repeat (n) push_word(pit_pkg::CMD_TICK, 3'($urandom_range(0, 7)),
			3'($urandom_range(0, 7)), 8'($urandom));
	endtask

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 8);
	endfunction

	// drive request side
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			expected_results.push_back(timer_step(cur_word));
			words_taken++;
			word_taken = 1'b1;
			if (words_taken % 150 == 0)
				quiet = !quiet;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!req_valid || word_taken)) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				cur_word = pending_words.pop_front();
				cmd <= cur_word.cmd;
				port_sel <= cur_word.port_sel;
				access_bytes <= cur_word.access_bytes;
				wdata <= cur_word.wdata;
				req_valid <= 1'b1;
				gap_left = draw_wait();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// check result side
	always @(posedge clk) begin
		pit_pkg::result_t exp_r;
		if (arst_n && rsp_valid && !rsp_stall) begin
			result_taken = 1'b1;
			if (expected_results.size() == 0) begin
				$error("result word with no expectation");
				mismatches++;
			end else begin
				exp_r = expected_results.pop_front();
				if (rdata !== exp_r.rdata) begin
					$error("rdata expected %0h actual %0h", exp_r.rdata, rdata);
					mismatches++;
				end
				if (access_error !== exp_r.access_error) begin
					$error("access_error expected %0b actual %0b", exp_r.access_error,
						access_error);
					mismatches++;
				end
				if (irq_pulse !== exp_r.irq_pulse) begin
					$error("irq_pulse expected %0b actual %0b", exp_r.irq_pulse, irq_pulse);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (result_taken) begin
			result_taken = 1'b0;
			stall_left = draw_wait();
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int r, ch, n;
		logic [2:0] m;
		logic [15:0] v;

		// directed
		push_word(pit_pkg::CMD_READ, 3'd0, 3'd1, 8'h00);
		push_word(pit_pkg::CMD_READ, 3'd0, 3'd1, 8'h00);
		push_ctrl(2'd0, pit_pkg::RW_BOTH, pit_pkg::MODE_2);
		push_count(0, 16'd1);
		push_count(0, 16'd3);
		push_ticks(4);
		push_ctrl(2'd1, pit_pkg::RW_BOTH, pit_pkg::MODE_0);
		push_count(1, 16'd0);
		push_ctrl(2'd2, pit_pkg::RW_BOTH, 3'd7);
		push_count(2, 16'd4);
		push_ctrl(2'd1, 2'd1, pit_pkg::MODE_0);
		push_ctrl(2'd0, pit_pkg::RW_BOTH, pit_pkg::MODE_1);
		push_ctrl(2'd0, pit_pkg::RW_BOTH, pit_pkg::MODE_5);
		push_ctrl(2'd0, pit_pkg::RW_BOTH, pit_pkg::MODE_6);
		push_word(pit_pkg::CMD_WRITE, pit_pkg::PORT_CTRL, 3'd1, 8'hff);
		push_word(pit_pkg::CMD_READ, 3'd2, 3'd1, 8'h00);
		push_word(pit_pkg::CMD_READ, pit_pkg::PORT_CTRL, 3'd1, 8'h00);
		push_word(pit_pkg::CMD_READ, 3'd7, 3'd1, 8'h00);
		push_word(pit_pkg::CMD_READ, 3'd5, 3'd1, 8'h00);
		push_word(pit_pkg::CMD_READ, pit_pkg::PORT_MISC, 3'd4, 8'h00);
		push_word(pit_pkg::CMD_WRITE, pit_pkg::PORT_MISC, 3'd0, 8'hff);
		push_word(pit_pkg::CMD_READ, 3'd0, 3'd2, 8'h00);
		push_word(CMD_NONE, 3'd7, 3'd7, 8'hff);

		while (pending_words.size() < ITEMS) begin
			r = $urandom_range(0, 99);
			ch = $urandom_range(0, 2);
			if (r < 15) begin
				case ($urandom_range(0, 5))
					0: m = pit_pkg::MODE_0;
					1: m = pit_pkg::MODE_2;
					2: m = pit_pkg::MODE_3;
					3: m = pit_pkg::MODE_4;
					4: m = pit_pkg::MODE_6;
					default: m = 3'd7;
				endcase
				push_ctrl(2'(ch), pit_pkg::RW_BOTH, m);
				n = $urandom_range(0, 9);
				v = n < 7 ? 16'($urandom_range(2, 40)) : n == 7 ? 16'($urandom_range(0, 1))
					: 16'($urandom);
				push_count(ch, v);
			end else if (r < 55) begin
				push_ticks($urandom_range(1, 20));
			end else if (r < 70) begin
				push_word(pit_pkg::CMD_READ, 3'(ch), 3'd1, 8'($urandom));
			end else if (r < 75) begin
				push_ctrl(2'(ch), pit_pkg::RW_LATCH, 3'($urandom_range(0, 7)));
			end else if (r < 80) begin
				push_word(pit_pkg::CMD_WRITE, pit_pkg::PORT_CTRL, 3'd1,
					8'hc0 | 8'($urandom_range(0, 63)));
			end else if (r < 84) begin
				push_word(2'($urandom_range(1, 2)), pit_pkg::PORT_MISC,
					3'($urandom_range(0, 7)), 8'($urandom));
			end else if (r < 95) begin
				push_word(pit_pkg::CMD_WRITE, 3'(ch), 3'd1, 8'($urandom));
			end else begin
				push_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), 8'($urandom));
			end
		end
		n = pending_words.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (words_taken == n && expected_results.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
